FILE: design/pic_pkg.sv
// shared constants, register indexes and saturation helpers for the particle step
// used by pic_div, by the top level particle_integrate_bounce_color and by the testbench
package pic_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int SCALE_BITS    = 16;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 48;
    localparam int PAY_W         = 129;
    localparam int T_W           = 19;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TIME_STEP = 3'd0,
        CFG_DAMPING   = 3'd1,
        CFG_EXTENT    = 3'd2,
        CFG_RADIUS    = 3'd3,
        CFG_SPEED_LIM = 3'd4,
        CFG_RAMP_LOW  = 3'd5,
        CFG_RAMP_MID  = 3'd6,
        CFG_RAMP_TOP  = 3'd7
    } cfg_addr_t;

    localparam logic [15:0] TIME_STEP_RST = 16'd1092;
    localparam logic [16:0] DAMPING_RST   = 17'd52429;
    localparam logic [31:0] EXTENT_RST    = 32'd39322400;
    localparam logic [31:0] RADIUS_RST    = 32'd327680;
    localparam logic [31:0] SPEED_LIM_RST = 32'd65536000;

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        hi = 34'sh0_7fff_ffff;
        lo = 34'sh3_8000_0000;
        if (v > hi) begin
            return 32'sh7fff_ffff;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
        if (v == 32'sh8000_0000) begin
            return 32'sh7fff_ffff;
        end
        return -v;
    endfunction

endpackage

FILE: design/pic_sqrt.sv
// pipelined integer square root, two result bits per stage, 64-bit radicand
// carries an opaque payload alongside; depends on nothing else
module pic_sqrt #(
    parameter int PW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [63:0]   in_rad,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [31:0]   out_root,
    output logic [PW-1:0] out_pay
);
    localparam int STEPS = 2;
    localparam int NS    = 32 / STEPS;

    logic [63:0]   n_reg   [0:NS-1];
    logic [63:0]   res_reg [0:NS-1];
    logic [PW-1:0] pay_reg [0:NS-1];
    logic          v_reg   [0:NS-1];

    for (genvar s = 0; s < NS; s++) begin : g_st
        logic [63:0]   n_in;
        logic [63:0]   res_in;
        logic [PW-1:0] pay_in;
        logic          v_in;
        logic [63:0]   n_next;
        logic [63:0]   res_next;

        if (s == 0) begin : g_first
            assign n_in   = in_rad;
            assign res_in = '0;
            assign pay_in = in_pay;
            assign v_in   = in_valid;
        end else begin : g_rest
            assign n_in   = n_reg[s-1];
            assign res_in = res_reg[s-1];
            assign pay_in = pay_reg[s-1];
            assign v_in   = v_reg[s-1];
        end

        always_comb begin
            logic [63:0] bitv;
            logic [63:0] trial;
            n_next   = n_in;
            res_next = res_in;
            for (int j = 0; j < STEPS; j++) begin
                bitv  = 64'd1 << (62 - 2 * (STEPS * s + j));
                trial = res_next + bitv;
                if (n_next >= trial) begin
                    n_next   = n_next - trial;
                    res_next = (res_next >> 1) + bitv;
                end else begin
                    res_next = res_next >> 1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (en) begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[s]   <= n_next;
                res_reg[s] <= res_next;
                pay_reg[s] <= pay_in;
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_root  = res_reg[NS-1][31:0];
    assign out_pay   = pay_reg[NS-1];

endmodule

FILE: design/pic_div.sv
// pipelined restoring divider for the ramp position, three quotient bits per stage
// uses pic_pkg for the quotient width
module pic_div #(
    parameter int PW = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [31:0]          in_speed,
    input  logic [31:0]          lim,
    input  logic [PW-1:0]        in_pay,
    output logic                 out_valid,
    output logic [pic_pkg::T_W-1:0] out_t,
    output logic [PW-1:0]        out_pay
);
    localparam int STEPS = 3;
    localparam int NS    = (pic_pkg::T_W + STEPS - 1) / STEPS;

    logic [32:0]             r_reg   [0:NS-1];
    logic [pic_pkg::T_W-1:0] q_reg   [0:NS-1];
    logic [PW-1:0]           pay_reg [0:NS-1];
    logic                    v_reg   [0:NS-1];

    for (genvar s = 0; s < NS; s++) begin : g_st
        logic [32:0]             r_in;
        logic [pic_pkg::T_W-1:0] q_in;
        logic [PW-1:0]           pay_in;
        logic                    v_in;
        logic [32:0]             r_next;
        logic [pic_pkg::T_W-1:0] q_next;

        if (s == 0) begin : g_first
            // speed limited to the saturation speed
            assign r_in   = (in_speed > lim) ? {1'b0, lim} : {1'b0, in_speed};
            assign q_in   = '0;
            assign pay_in = in_pay;
            assign v_in   = in_valid;
        end else begin : g_rest
            assign r_in   = r_reg[s-1];
            assign q_in   = q_reg[s-1];
            assign pay_in = pay_reg[s-1];
            assign v_in   = v_reg[s-1];
        end

        always_comb begin
            logic        cmp;
            logic [32:0] rs;
            cmp    = 1'b0;
            rs     = '0;
            r_next = r_in;
            q_next = q_in;
            for (int j = 0; j < STEPS; j++) begin
                if (STEPS * s + j < pic_pkg::T_W) begin
                    cmp    = (r_next >= {1'b0, lim});
                    rs     = cmp ? (r_next - {1'b0, lim}) : r_next;
                    r_next = {rs[31:0], 1'b0};
                    q_next = {q_next[pic_pkg::T_W-2:0], cmp};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (en) begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[s]   <= r_next;
                q_reg[s]   <= q_next;
                pay_reg[s] <= pay_in;
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_t     = q_reg[NS-1];
    assign out_pay   = pay_reg[NS-1];

endmodule

FILE: design/particle_integrate_bounce_color.sv
// top level of the particle step: euler integration, wall bounce, speed color ramp
// depends on pic_pkg, pic_sqrt and pic_div

// Takes one particle word per clock and gives one result word per clock. The
// pipeline holds 11 stages of integration, bounce and squaring, 16 square-root
// stages, 7 divider stages for the ramp position and then the output
// register. Every unit is fully pipelined, so the rate is one word per cycle;
// a stall on the result side holds the whole pipeline. Write the configuration
// only while no word is in flight.
module particle_integrate_bounce_color #(
    parameter int FRAC_BITS = pic_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [pic_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [pic_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // pos_x, pos_y, vel_x, vel_y, force_x, force_y
    input  logic [191:0]                  s_tdata,
    // mode
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_pos_x, out_pos_y, out_vel_x, out_vel_y, red, green, blue
    output logic [151:0]                  m_tdata
);
    localparam int EXW = 16 + FRAC_BITS + 1;
    localparam int CW  = ((EXW > 34) ? EXW : 34) + 1;
    localparam logic signed [CW-1:0] CL_HI = CW'(64'sh7fff_ffff);
    localparam logic signed [CW-1:0] CL_LO = CW'(-64'sh8000_0000);

    logic [15:0] time_step_reg;
    logic [16:0] damping_reg;
    logic [31:0] extent_reg;
    logic [31:0] radius_reg;
    logic [31:0] speed_lim_reg;
    logic [47:0] ramp_low_reg;
    logic [47:0] ramp_mid_reg;
    logic [23:0] ramp_top_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg <= pic_pkg::TIME_STEP_RST;
            damping_reg   <= pic_pkg::DAMPING_RST;
            extent_reg    <= pic_pkg::EXTENT_RST;
            radius_reg    <= pic_pkg::RADIUS_RST;
            speed_lim_reg <= pic_pkg::SPEED_LIM_RST;
            ramp_low_reg  <= '0;
            ramp_mid_reg  <= '0;
            ramp_top_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (pic_pkg::cfg_addr_t'(cfg_addr))
                pic_pkg::CFG_TIME_STEP: time_step_reg <= cfg_wdata[15:0];
                pic_pkg::CFG_DAMPING:   damping_reg   <= cfg_wdata[16:0];
                pic_pkg::CFG_EXTENT:    extent_reg    <= cfg_wdata[31:0];
                pic_pkg::CFG_RADIUS:    radius_reg    <= cfg_wdata[31:0];
                pic_pkg::CFG_SPEED_LIM: speed_lim_reg <= cfg_wdata[31:0];
                pic_pkg::CFG_RAMP_LOW:  ramp_low_reg  <= cfg_wdata[47:0];
                pic_pkg::CFG_RAMP_MID:  ramp_mid_reg  <= cfg_wdata[47:0];
                pic_pkg::CFG_RAMP_TOP:  ramp_top_reg  <= cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    function automatic logic [32:0] wall(input logic signed [31:0] p,
                                         input logic [15:0] units,
                                         input logic [31:0] rad);
        logic signed [CW-1:0] pw;
        logic signed [CW-1:0] rw;
        logic signed [CW-1:0] ew;
        logic signed [CW-1:0] diff;
        pw   = CW'(p);
        rw   = CW'({1'b0, rad});
        ew   = CW'({units, {FRAC_BITS{1'b0}}});
        diff = ew - rw;
        if (pw < rw) begin
            return {1'b1, rad[31] ? 32'h7fff_ffff : rad};
        end else if (pw + rw >= ew) begin
            if (diff > CL_HI) begin
                return {1'b1, 32'h7fff_ffff};
            end else if (diff < CL_LO) begin
                return {1'b1, 32'h8000_0000};
            end
            return {1'b1, diff[31:0]};
        end
        return {1'b0, p};
    endfunction

    function automatic logic [23:0] ramp_entry(input logic [2:0] i);
        case (i)
            3'd0:    return ramp_low_reg[23:0];
            3'd1:    return ramp_low_reg[47:24];
            3'd2:    return ramp_mid_reg[23:0];
            3'd3:    return ramp_mid_reg[47:24];
            default: return ramp_top_reg;
        endcase
    endfunction

    logic en;
    logic out_valid_reg;
    logic [151:0] out_data_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    logic signed [31:0] in_px, in_py, in_vx, in_vy, in_fx, in_fy;
    logic signed [16:0] ts_s;
    logic signed [17:0] dmp_s;
    assign in_px = s_tdata[31:0];
    assign in_py = s_tdata[63:32];
    assign in_vx = s_tdata[95:64];
    assign in_vy = s_tdata[127:96];
    assign in_fx = s_tdata[159:128];
    assign in_fy = s_tdata[191:160];
    assign ts_s  = $signed({1'b0, time_step_reg});
    assign dmp_s = $signed({1'b0, damping_reg});

    // stage a: force times time step
    logic va_reg, ma_reg;
    logic signed [31:0] pxa_reg, pya_reg, vxa_reg, vya_reg;
    logic signed [48:0] fxa_reg, fya_reg;
    // stage b: velocity update
    logic vb_reg, mb_reg;
    logic signed [31:0] pxb_reg, pyb_reg, vxb_reg, vyb_reg;
    // stage c: velocity times time step
    logic vc_reg, mc_reg;
    logic signed [31:0] pxc_reg, pyc_reg, vxc_reg, vyc_reg;
    logic signed [48:0] dxc_reg, dyc_reg;
    // stage d: position update
    logic vd_reg, md_reg;
    logic signed [31:0] pxd_reg, pyd_reg, vxd_reg, vyd_reg;
    // stage e: wall tests and x reflection
    logic ve_reg, me_reg, hxe_reg, hye_reg;
    logic signed [31:0] pxe_reg, pye_reg, vxe_reg, vye_reg;
    // stage f: damping products after an x hit
    logic vf_reg, mf_reg, hxf_reg, hyf_reg;
    logic signed [31:0] pxf_reg, pyf_reg, vxf_reg, vyf_reg;
    logic signed [49:0] kxf_reg, kyf_reg;
    // stage g: x damping applied, y reflection
    logic vg_reg, mg_reg, hyg_reg;
    logic signed [31:0] pxg_reg, pyg_reg, vxg_reg, vyg_reg;
    // stage h: damping products after a y hit
    logic vh_reg, mh_reg, hyh_reg;
    logic signed [31:0] pxh_reg, pyh_reg, vxh_reg, vyh_reg;
    logic signed [49:0] kxh_reg, kyh_reg;
    // stage i: final velocity
    logic vi_reg, mi_reg;
    logic signed [31:0] pxi_reg, pyi_reg, vxi_reg, vyi_reg;
    // stage j: squares
    logic vj_reg;
    logic [pic_pkg::PAY_W-1:0] payj_reg;
    logic signed [63:0] sqx_reg, sqy_reg;
    // stage k: squared speed
    logic vk_reg;
    logic [pic_pkg::PAY_W-1:0] payk_reg;
    logic [63:0] sum_reg;

    logic signed [31:0] vxb_next, vyb_next, pxd_next, pyd_next, vxe_next;
    logic signed [31:0] vxg_next, vyg_next, vxi_next, vyi_next;
    logic [32:0] wx, wy;
    logic hxe_next;

    assign vxb_next = ma_reg ? vxa_reg :
        pic_pkg::sat34(34'(vxa_reg) + 34'($signed(fxa_reg[48:16])));
    assign vyb_next = ma_reg ? vya_reg :
        pic_pkg::sat34(34'(vya_reg) + 34'($signed(fya_reg[48:16])));
    assign pxd_next = pic_pkg::sat34(34'(pxc_reg) + 34'($signed(dxc_reg[48:16])));
    assign pyd_next = pic_pkg::sat34(34'(pyc_reg) + 34'($signed(dyc_reg[48:16])));
    assign wx       = wall(pxd_reg, extent_reg[15:0], radius_reg);
    assign wy       = wall(pyd_reg, extent_reg[31:16], radius_reg);
    assign hxe_next = wx[32] && !md_reg;
    assign vxe_next = hxe_next ? pic_pkg::neg_sat(vxd_reg) : vxd_reg;
    assign vxg_next = hxf_reg ? pic_pkg::sat34(kxf_reg[49:16]) : vxf_reg;
    assign vyg_next = hxf_reg ? pic_pkg::sat34(kyf_reg[49:16]) : vyf_reg;
    assign vxi_next = hyh_reg ? pic_pkg::sat34(kxh_reg[49:16]) : vxh_reg;
    assign vyi_next = hyh_reg ? pic_pkg::sat34(kyh_reg[49:16]) : vyh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
            vh_reg <= 1'b0;
            vi_reg <= 1'b0;
            vj_reg <= 1'b0;
            vk_reg <= 1'b0;
        end else if (en) begin
            va_reg <= s_tvalid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
            vf_reg <= ve_reg;
            vg_reg <= vf_reg;
            vh_reg <= vg_reg;
            vi_reg <= vh_reg;
            vj_reg <= vi_reg;
            vk_reg <= vj_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ma_reg  <= s_tuser;
            pxa_reg <= in_px;
            pya_reg <= in_py;
            vxa_reg <= in_vx;
            vya_reg <= in_vy;
            fxa_reg <= in_fx * ts_s;
            fya_reg <= in_fy * ts_s;

            mb_reg  <= ma_reg;
            pxb_reg <= pxa_reg;
            pyb_reg <= pya_reg;
            vxb_reg <= vxb_next;
            vyb_reg <= vyb_next;

            mc_reg  <= mb_reg;
            pxc_reg <= pxb_reg;
            pyc_reg <= pyb_reg;
            vxc_reg <= vxb_reg;
            vyc_reg <= vyb_reg;
            dxc_reg <= vxb_reg * ts_s;
            dyc_reg <= vyb_reg * ts_s;

            md_reg  <= mc_reg;
            pxd_reg <= pxd_next;
            pyd_reg <= pyd_next;
            vxd_reg <= vxc_reg;
            vyd_reg <= vyc_reg;

            me_reg  <= md_reg;
            hxe_reg <= hxe_next;
            hye_reg <= wy[32] && !md_reg;
            pxe_reg <= wx[31:0];
            pye_reg <= wy[31:0];
            vxe_reg <= vxe_next;
            vye_reg <= vyd_reg;

            mf_reg  <= me_reg;
            hxf_reg <= hxe_reg;
            hyf_reg <= hye_reg;
            pxf_reg <= pxe_reg;
            pyf_reg <= pye_reg;
            vxf_reg <= vxe_reg;
            vyf_reg <= vye_reg;
            kxf_reg <= vxe_reg * dmp_s;
            kyf_reg <= vye_reg * dmp_s;

            mg_reg  <= mf_reg;
            hyg_reg <= hyf_reg;
            pxg_reg <= pxf_reg;
            pyg_reg <= pyf_reg;
            vxg_reg <= vxg_next;
            vyg_reg <= hyf_reg ? pic_pkg::neg_sat(vyg_next) : vyg_next;

            mh_reg  <= mg_reg;
            hyh_reg <= hyg_reg;
            pxh_reg <= pxg_reg;
            pyh_reg <= pyg_reg;
            vxh_reg <= vxg_reg;
            vyh_reg <= vyg_reg;
            kxh_reg <= vxg_reg * dmp_s;
            kyh_reg <= vyg_reg * dmp_s;

            mi_reg  <= mh_reg;
            pxi_reg <= pxh_reg;
            pyi_reg <= pyh_reg;
            vxi_reg <= vxi_next;
            vyi_reg <= vyi_next;

            payj_reg <= {mi_reg, vyi_reg, vxi_reg, pyi_reg, pxi_reg};
            sqx_reg  <= vxi_reg * vxi_reg;
            sqy_reg  <= vyi_reg * vyi_reg;

            payk_reg <= payj_reg;
            sum_reg  <= $unsigned(sqx_reg) + $unsigned(sqy_reg);
        end
    end

    logic sq_valid;
    logic [31:0] speed;
    logic [pic_pkg::PAY_W-1:0] sq_pay;

    pic_sqrt #(.PW(pic_pkg::PAY_W)) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vk_reg),
        .in_rad    (sum_reg),
        .in_pay    (payk_reg),
        .out_valid (sq_valid),
        .out_root  (speed),
        .out_pay   (sq_pay)
    );

    logic dv_valid;
    logic [pic_pkg::T_W-1:0] ramp_t;
    logic [pic_pkg::PAY_W-1:0] dv_pay;

    pic_div #(.PW(pic_pkg::PAY_W)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_speed  (speed),
        .lim       (speed_lim_reg),
        .in_pay    (sq_pay),
        .out_valid (dv_valid),
        .out_t     (ramp_t),
        .out_pay   (dv_pay)
    );

    // blend of two adjacent ramp colors; the top color at or past the speed limit, black in predict mode
    logic [23:0] color;
    always_comb begin
        logic [2:0]  q;
        logic [15:0] r;
        logic [23:0] c1;
        logic [23:0] c2;
        logic [24:0] acc;
        q     = ramp_t[pic_pkg::T_W-1:16];
        r     = ramp_t[15:0];
        c1    = ramp_entry(q);
        c2    = ramp_entry(q + 3'd1);
        acc   = '0;
        color = '0;
        if (q >= 3'd4) begin
            color = ramp_top_reg;
        end else begin
            for (int c = 0; c < 3; c++) begin
                acc = 25'(c1[8*c +: 8]) * 25'(17'd65536 - {1'b0, r})
                    + 25'(c2[8*c +: 8]) * 25'(r);
                color[8*c +: 8] = acc[23:16];
            end
        end
        if (dv_pay[pic_pkg::PAY_W-1]) begin
            color = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= {color[7:0], color[15:8], color[23:16],
                             dv_pay[pic_pkg::PAY_W-2:0]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTH
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> va_reg)
        else $error("accepted word missing from first stage");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> $stable(va_reg) && $stable(vk_reg))
        else $error("pipeline moved during stall");
`endif

endmodule

FILE: tb/pic_tb_pkg.sv
// testbench types for the particle step: input modes and the packed result word
// shared by the checker and the testbench top, no other dependency
package pic_tb_pkg;

    typedef enum logic {
        MODE_STEP    = 1'b0,
        MODE_PREDICT = 1'b1
    } particle_mode_t;

    typedef struct packed {
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [31:0] vel_y;
        logic [31:0] vel_x;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
    } particle_result_t;

endpackage

FILE: tb/particle_step_checker.sv
// watches both streams and the register port of particle_integrate_bounce_color,
// predicts each result word in fixed point and compares it; uses pic_pkg, pic_tb_pkg
module particle_step_checker
    import pic_pkg::*;
    import pic_tb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [191:0]          s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [151:0]          m_tdata,
    output int                    n_errors,
    output int                    n_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0] dt;
    logic [16:0] damp;
    logic [31:0] extent;
    logic [31:0] rad;
    logic [31:0] vlim;
    logic [47:0] ramp_lo;
    logic [47:0] ramp_mid;
    logic [23:0] ramp_top;

    particle_result_t result_q[$];
    int errs;

    function automatic longint sat(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint scale(input longint v, input longint k);
        return sat((v * k) >>> 16);
    endfunction

    function automatic bit wall_hit(inout longint p, input longint units);
        longint r;
        longint lim;
        r = longint'(rad);
        lim = units <<< FRAC_BITS_DEF;
        if (p - r < 0) begin
            p = sat(r);
            return 1'b1;
        end
        if (p + r >= lim) begin
            p = sat(lim - r);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [23:0] ramp_entry(input int i);
        case (i)
            0: return ramp_lo[23:0];
            1: return ramp_lo[47:24];
            2: return ramp_mid[23:0];
            3: return ramp_mid[47:24];
            default: return ramp_top;
        endcase
    endfunction

    function automatic logic [23:0] speed_color(input longint unsigned spd);
        longint unsigned lim;
        longint unsigned t;
        longint unsigned q;
        longint unsigned w;
        longint unsigned a;
        longint unsigned b;
        logic [23:0] c1;
        logic [23:0] c2;
        logic [23:0] col;
        lim = longint'(vlim);
        if (lim == 0) return ramp_entry(4);
        if (spd > lim) spd = lim;
        t = ((spd * 4) << 16) / lim;
        q = t >> 16;
        w = t & 64'hffff;
        if (q >= 4) return ramp_entry(4);
        c1 = ramp_entry(int'(q));
        c2 = ramp_entry(int'(q) + 1);
        for (int sh = 0; sh < 24; sh += 8) begin
            a = (c1 >> sh) & 8'hff;
            b = (c2 >> sh) & 8'hff;
            col[sh +: 8] = 8'((a * (65536 - w) + b * w) >> 16);
        end
        return col;
    endfunction

    function automatic particle_result_t step_particle(input logic mode,
                                                       input logic [191:0] d);
        longint px;
        longint py;
        longint vx;
        longint vy;
        longint k;
        logic [23:0] col;
        bit hit;
        particle_result_t res;
        px = longint'($signed(d[31:0]));
        py = longint'($signed(d[63:32]));
        vx = longint'($signed(d[95:64]));
        vy = longint'($signed(d[127:96]));
        k = longint'(dt);
        col = '0;
        if (particle_mode_t'(mode) == MODE_STEP) begin
            vx = sat(vx + ((longint'($signed(d[159:128])) * k) >>> 16));
            vy = sat(vy + ((longint'($signed(d[191:160])) * k) >>> 16));
            px = sat(px + ((vx * k) >>> 16));
            py = sat(py + ((vy * k) >>> 16));
            if (wall_hit(px, longint'(extent[15:0]))) begin
                vx = scale(sat(-vx), longint'(damp));
                vy = scale(vy, longint'(damp));
            end
            if (wall_hit(py, longint'(extent[31:16]))) begin
                vy = scale(sat(-vy), longint'(damp));
                vx = scale(vx, longint'(damp));
            end
            col = speed_color(int_sqrt(longint'(vx * vx) + longint'(vy * vy)));
        end else begin
            px = sat(px + ((vx * k) >>> 16));
            py = sat(py + ((vy * k) >>> 16));
            hit = wall_hit(px, longint'(extent[15:0]));
            hit = wall_hit(py, longint'(extent[31:16]));
        end
        res.pos_x = px[31:0];
        res.pos_y = py[31:0];
        res.vel_x = vx[31:0];
        res.vel_y = vy[31:0];
        res.red = col[23:16];
        res.green = col[15:8];
        res.blue = col[7:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        particle_result_t got;
        particle_result_t want;
        if (!aresetn) begin
            dt <= TIME_STEP_RST;
            damp <= DAMPING_RST;
            extent <= EXTENT_RST;
            rad <= RADIUS_RST;
            vlim <= SPEED_LIM_RST;
            ramp_lo <= '0;
            ramp_mid <= '0;
            ramp_top <= '0;
            result_q.delete();
            errs = 0;
            n_errors <= 0;
            n_pending <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr_t'(cfg_addr))
                    CFG_TIME_STEP: dt <= cfg_wdata[15:0];
                    CFG_DAMPING:   damp <= cfg_wdata[16:0];
                    CFG_EXTENT:    extent <= cfg_wdata[31:0];
                    CFG_RADIUS:    rad <= cfg_wdata[31:0];
                    CFG_SPEED_LIM: vlim <= cfg_wdata[31:0];
                    CFG_RAMP_LOW:  ramp_lo <= cfg_wdata[47:0];
                    CFG_RAMP_MID:  ramp_mid <= cfg_wdata[47:0];
                    CFG_RAMP_TOP:  ramp_top <= cfg_wdata[23:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                result_q.push_back(step_particle(s_tuser, s_tdata));
            end
            if (m_tvalid && m_tready) begin
                got = particle_result_t'(m_tdata);
                if (result_q.size() == 0) begin
                    errs++;
                    if (errs <= 10) $display("unexpected result word %h", m_tdata);
                end else begin
                    want = result_q.pop_front();
                    if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
                        got.vel_x !== want.vel_x || got.vel_y !== want.vel_y ||
                        got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue) begin
                        errs++;
                        if (errs <= 10) begin
                            $display("mismatch pos %h %h vel %h %h rgb %h %h %h",
                                     got.pos_x, got.pos_y, got.vel_x, got.vel_y,
                                     got.red, got.green, got.blue);
                            $display("  expected pos %h %h vel %h %h rgb %h %h %h",
                                     want.pos_x, want.pos_y, want.vel_x, want.vel_y,
                                     want.red, want.green, want.blue);
                        end
                    end
                end
            end
            n_errors <= errs;
            n_pending <= result_q.size();
        end
    end

endmodule

FILE: tb/testbench.sv
// stimulus and verdict for particle_integrate_bounce_color: directed particles,
// then random ones under several register settings; depends on particle_step_checker
module testbench;
    import pic_pkg::*;
    import pic_tb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [191:0]          s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [151:0]          m_tdata;
    int                    n_errors;
    int                    n_pending;

    logic        quiet;
    logic        hold_req;
    logic        hold_done;
    int          hold_cnt;
    int          stall_cnt;
    int          cycles;
    logic [31:0] cur_extent;
    logic [31:0] cur_rad;

    particle_integrate_bounce_color i_dut (.*);

    particle_step_checker i_checker (.*);

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // result side: short random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_cnt <= 0;
            hold_done <= 1'b0;
            stall_cnt <= 0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt <= 400;
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (m_tvalid && m_tready && !quiet) stall_cnt <= $urandom_range(0, 4);
        end
    end

    task automatic write_reg(input cfg_addr_t a, input logic [47:0] v);
        cfg_wr_en <= 1'b1;
        cfg_addr <= a;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (a == CFG_EXTENT) cur_extent = v[31:0];
        if (a == CFG_RADIUS) cur_rad = v[31:0];
    endtask

    task automatic send_word(input particle_mode_t mode, input logic [191:0] d);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= mode;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_particle(input particle_mode_t mode, input logic [31:0] px,
                                 input logic [31:0] py, input logic [31:0] vx,
                                 input logic [31:0] vy, input logic [31:0] fx,
                                 input logic [31:0] fy);
        send_word(mode, {fy, fx, vy, vx, py, px});
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic logic [31:0] coord(input logic [15:0] units);
        longint span;
        longint p;
        span = longint'(units) << 16;
        case ($urandom_range(0, 3))
            0: p = longint'(cur_rad) + $signed($urandom_range(0, 8192)) - 4096;
            1: p = span - longint'(cur_rad) + $signed($urandom_range(0, 8192)) - 4096;
            default: p = longint'($urandom) % (span + 1);
        endcase
        return p[31:0];
    endfunction

    function automatic logic [31:0] small_val(input int bits);
        return $urandom_range(0, (1 << bits) - 1) - (1 << (bits - 1));
    endfunction

    task automatic random_particles(input int n);
        particle_mode_t mode;
        for (int i = 0; i < n; i++) begin
            mode = particle_mode_t'($urandom_range(0, 1));
            if ($urandom_range(0, 9) < 6) begin
                send_particle(mode, coord(cur_extent[15:0]), coord(cur_extent[31:16]),
                              small_val(26), small_val(26), small_val(28), small_val(28));
            end else begin
                send_particle(mode, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom);
            end
        end
    endtask

    task automatic random_regs();
        write_reg(CFG_TIME_STEP, $urandom_range(0, 65535));
        write_reg(CFG_DAMPING, $urandom_range(0, 65536));
        write_reg(CFG_EXTENT, {$urandom_range(0, 2000), 16'($urandom_range(0, 2000))});
        write_reg(CFG_RADIUS, $urandom_range(0, 1 << 22));
        write_reg(CFG_SPEED_LIM, $urandom_range(1, 32'hffffffff));
        write_reg(CFG_RAMP_LOW, {$urandom, $urandom});
        write_reg(CFG_RAMP_MID, {$urandom, $urandom});
        write_reg(CFG_RAMP_TOP, $urandom);
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        quiet = 1'b0;
        hold_req = 1'b0;
        cycles = 0;
        cur_extent = EXTENT_RST;
        cur_rad = RADIUS_RST;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_reg(CFG_RAMP_LOW, 48'h00ff00_0000ff);
        write_reg(CFG_RAMP_MID, 48'hff0000_ffff00);
        write_reg(CFG_RAMP_TOP, 24'hffffff);

        // directed: rest, walls, saturation, mode 1
        send_particle(MODE_STEP, 32'h012c0000, 32'h012c0000, 0, 0, 0, 0);
        send_particle(MODE_PREDICT, 32'h012c0000, 32'h012c0000, 32'h00640000,
                      32'hff9c0000, 32'h7fffffff, 32'h80000000);
        send_particle(MODE_STEP, 32'h00010000, 32'h012c0000, 32'hfe000000, 0, 0, 0);
        send_particle(MODE_STEP, 32'h02550000, 32'h012c0000, 32'h02000000, 0, 0, 0);
        send_particle(MODE_STEP, 32'h012c0000, 32'h00010000, 0, 32'hfe000000, 0, 0);
        send_particle(MODE_STEP, 32'h012c0000, 32'h02550000, 0, 32'h02000000, 0, 0);
        send_particle(MODE_STEP, 32'h00010000, 32'h00010000, 32'h80000000,
                      32'h80000000, 32'h80000000, 32'h80000000);
        send_particle(MODE_STEP, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_particle(MODE_STEP, 32'h80000000, 32'h80000000, 32'h7fffffff,
                      32'h80000000, 32'h7fffffff, 32'h80000000);
        send_particle(MODE_PREDICT, 32'h80000000, 32'h7fffffff, 32'h80000000,
                      32'h7fffffff, 0, 0);
        send_particle(MODE_PREDICT, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                      32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_particle(MODE_STEP, 32'h012c0000, 32'h012c0000, 32'h01f40000, 0, 0, 0);
        send_particle(MODE_STEP, 32'h012c0000, 32'h012c0000, 32'h02ee0000,
                      32'h02ee0000, 0, 0);
        send_particle(MODE_STEP, 32'h012c0000, 32'h012c0000, 32'h00fa8000,
                      32'hff058000, 32'h00100000, 32'hfff00000);
        send_particle(MODE_STEP, 32'h00050000, 32'h00050000, 32'hffffffff,
                      32'hffffffff, 32'hffffffff, 32'hffffffff);
        random_particles(150);
        // pause until every result is back
        drain();
        random_particles(150);
        drain();

        // extremes high, with a long hold-off on the result side
        write_reg(CFG_TIME_STEP, 16'hffff);
        write_reg(CFG_DAMPING, 17'h10000);
        write_reg(CFG_EXTENT, 32'hffffffff);
        write_reg(CFG_RADIUS, 32'h0);
        write_reg(CFG_SPEED_LIM, 32'h1);
        hold_req <= 1'b1;
        random_particles(200);
        drain();

        // extremes low; world smaller than twice the radius
        write_reg(CFG_TIME_STEP, 16'h0);
        write_reg(CFG_DAMPING, 17'h0);
        write_reg(CFG_EXTENT, 32'h0);
        write_reg(CFG_RADIUS, 32'hffffffff);
        write_reg(CFG_SPEED_LIM, 32'h0);
        random_particles(150);
        drain();

        write_reg(CFG_TIME_STEP, 16'd4369);
        write_reg(CFG_DAMPING, 17'd40000);
        write_reg(CFG_EXTENT, {16'd8, 16'd8});
        write_reg(CFG_RADIUS, 32'h00060000);
        write_reg(CFG_SPEED_LIM, 32'hffffffff);
        write_reg(CFG_RAMP_LOW, 48'hffffffffffff);
        write_reg(CFG_RAMP_MID, 48'h0);
        write_reg(CFG_RAMP_TOP, 24'hffffff);
        quiet <= 1'b1;
        random_particles(250);
        drain();
        quiet <= 1'b0;

        for (int p = 0; p < 3; p++) begin
            random_regs();
            random_particles(210);
            drain();
        end

        if (n_errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

FILE: files.f
design/pic_pkg.sv
design/pic_sqrt.sv
design/pic_div.sv
design/particle_integrate_bounce_color.sv
tb/pic_tb_pkg.sv
tb/particle_step_checker.sv
tb/testbench.sv
